// ===== hdl/mbhw_pkg.sv =====
// Package for the media box header walker.
// Holds the status codes, the result struct and the known box type table.
// No dependencies.
package mbhw_pkg;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_SIZE_ZERO = 2'd1,
    STATUS_MALFORMED = 2'd2
  } status_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] box_type;
    logic [63:0] payload_length;
    status_t     status;
  } result_t;

  localparam int KNOWN_COUNT = 53;
  localparam logic [3:0] SHORT_HEADER_BYTES = 4'd8;
  localparam logic [31:0] SIZE_EXTENDED = 32'd1;
  localparam logic [31:0] SIZE_MIN = 32'd8;
  localparam logic [63:0] EXT_SIZE_MIN = 64'd16;

  localparam logic [31:0] KNOWN_TYPES [KNOWN_COUNT] = '{
    "ftyp", "cmov", "cmvd", "co64", "ctts", "dcom", "dinf", "edts", "elst",
    "fiel", "free", "gmhd", "hdlr", "iods", "ipro", "junk", "mdat", "mdhd",
    "mdia", "meta", "mfra", "minf", "moof", "moov", "mvex", "mvhd", "pict",
    "pnot", "rdrf", "rmcd", "rmcs", "rmda", "rmdr", "rmqu", "rmra", "rmvc",
    "sinf", "skip", "smhd", "stbl", "stco", "stsc", "stsd", "stss", "stsz",
    "stts", "tkhd", "traf", "trak", "uuid", "vmhd", "wide", "wfex"
  };

  function automatic logic is_known(input logic [31:0] t);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < KNOWN_COUNT; i++) begin
      if (KNOWN_TYPES[i] == t) begin
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

endpackage

// ===== hdl/media_box_header_walker_top.sv =====
// Top level of the media box header walker: input handshake, walker core and
// a result register with a skid stage. Depends on mbhw_pkg and mbhw_walker.
//
//   channel | signals                                   | direction
//   in      | in_valid, in_stall, data_byte             | byte stream in
//   out     | out_valid, out_stall, box_type,           | box requests out
//           | payload_length, status                    |
//
// One byte is taken every cycle while in_stall is low; the result for the
// byte that completes a header is registered. The skid register lets one more
// result wait while the output is stalled; in_stall rises only when it is full.
// Synchronous reset clears the walker state and both result stages.
module media_box_header_walker_top
  import mbhw_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] box_type,
  output logic [63:0] payload_length,
  output logic [1:0]  status
);

  result_t res;
  result_t out_reg;
  result_t skid;
  logic    take;
  logic    out_take;

  assign take     = in_valid && !in_stall;
  assign out_take = out_reg.valid && !out_stall;
  assign in_stall = skid.valid;

  mbhw_walker u_walker (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .data_byte (data_byte),
    .result    (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_reg.valid <= 1'b0;
      skid.valid    <= 1'b0;
    end else if (skid.valid) begin
      if (out_take) begin
        out_reg    <= skid;
        skid.valid <= 1'b0;
      end
    end else if (take && res.valid) begin
      if (!out_reg.valid || out_take) begin
        out_reg <= res;
      end else begin
        skid <= res;
      end
    end else if (out_take) begin
      out_reg.valid <= 1'b0;
    end
  end

  assign out_valid      = out_reg.valid;
  assign box_type       = out_reg.box_type;
  assign payload_length = out_reg.payload_length;
  assign status         = out_reg.status;

  assert property (@(posedge clk) disable iff (rst) in_stall |-> out_valid)
    else $error("Skid register holds a request while the output is empty.");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && status != STATUS_OK |-> payload_length == 64'd0)
    else $error("Error status carries a nonzero payload length.");

  assert property (@(posedge clk) disable iff (rst)
    in_stall && !out_stall |=> out_valid && !in_stall)
    else $error("Skid request was not moved to the output.");

endmodule

// ===== hdl/mbhw_walker.sv =====
// Header walker core: header collection, payload skip and end-of-stream state.
// Produces at most one result for each accepted byte; depends on mbhw_pkg.
module mbhw_walker
  import mbhw_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        take,
  input  logic [7:0]  data_byte,
  output result_t     result
);

  logic [3:0]  header_byte_count;
  logic [31:0] size_word;
  logic [31:0] type_word;
  logic [63:0] extended_size;
  logic [63:0] skip_remaining;
  logic        skip_to_end;

  logic [3:0]  count_next;
  logic [31:0] size_next;
  logic [31:0] type_next;
  logic [63:0] ext_next;
  logic        active;
  logic        complete;
  logic        known;
  status_t     st;
  logic [63:0] len;

  always_comb begin
    active     = !skip_to_end && (skip_remaining == 64'd0);
    count_next = header_byte_count + 4'd1;
    size_next  = size_word;
    type_next  = type_word;
    ext_next   = extended_size;
    if (header_byte_count < 4'd4) begin
      size_next = {size_word[23:0], data_byte};
    end else if (header_byte_count < SHORT_HEADER_BYTES) begin
      type_next = {type_word[23:0], data_byte};
    end else begin
      ext_next = {extended_size[55:0], data_byte};
    end
    complete = (count_next == 4'd0)
            || (count_next == SHORT_HEADER_BYTES && size_next != SIZE_EXTENDED);
    st  = STATUS_OK;
    len = 64'd0;
    if (size_next == SIZE_EXTENDED) begin
      if (ext_next < EXT_SIZE_MIN) begin
        st = STATUS_MALFORMED;
      end else begin
        len = ext_next - EXT_SIZE_MIN;
      end
    end else if (size_next == 32'd0) begin
      st = STATUS_SIZE_ZERO;
    end else if (size_next < SIZE_MIN) begin
      st = STATUS_MALFORMED;
    end else begin
      len = {32'd0, size_next - SIZE_MIN};
    end
    known = is_known(type_next);

    result.valid          = active && complete && (st != STATUS_OK || known);
    result.box_type       = type_next;
    result.payload_length = len;
    result.status         = st;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_byte_count <= 4'd0;
      size_word         <= 32'd0;
      type_word         <= 32'd0;
      extended_size     <= 64'd0;
      skip_remaining    <= 64'd0;
      skip_to_end       <= 1'b0;
    end else if (take && !skip_to_end) begin
      if (skip_remaining != 64'd0) begin
        skip_remaining <= skip_remaining - 64'd1;
      end else if (complete) begin
        header_byte_count <= 4'd0;
        size_word         <= 32'd0;
        type_word         <= 32'd0;
        extended_size     <= 64'd0;
        if (st != STATUS_OK) begin
          skip_to_end <= 1'b1;
        end else if (known) begin
          skip_remaining <= len;
        end
      end else begin
        header_byte_count <= count_next;
        size_word         <= size_next;
        type_word         <= type_next;
        extended_size     <= ext_next;
      end
    end
  end

endmodule

// ===== sim/media_box_header_walker_top_test.sv =====
// Self-checking testbench for media_box_header_walker_top: streams media file bytes with
// random bursts and output stalls, predicts each box report and compares it on arrival.
// Depends on mbhw_pkg and the walker RTL.
module media_box_header_walker_top_test;
  import mbhw_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD = 8;
  localparam int CYCLE_LIMIT = 500000;
  localparam int DRAIN_CYCLES = 16;
  localparam int HOLD_CYCLES = 300;
  localparam int TYPE_COUNT = 53;

  localparam logic [31:0] BOX_TYPES [TYPE_COUNT] = '{
    "ftyp", "cmov", "cmvd", "co64", "ctts", "dcom", "dinf", "edts", "elst",
    "fiel", "free", "gmhd", "hdlr", "iods", "ipro", "junk", "mdat", "mdhd",
    "mdia", "meta", "mfra", "minf", "moof", "moov", "mvex", "mvhd", "pict",
    "pnot", "rdrf", "rmcd", "rmcs", "rmda", "rmdr", "rmqu", "rmra", "rmvc",
    "sinf", "skip", "smhd", "stbl", "stco", "stsc", "stsd", "stss", "stsz",
    "stts", "tkhd", "traf", "trak", "uuid", "vmhd", "wide", "wfex"
  };

  typedef struct {
    logic [7:0] value;
    bit         hold;
  } stream_byte_t;

  typedef struct packed {
    logic [31:0] box_type;
    logic [63:0] len;
    status_t     st;
  } box_report_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = 8'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] box_type;
  logic [63:0] payload_length;
  logic [1:0]  status;

  media_box_header_walker_top dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .data_byte      (data_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .box_type       (box_type),
    .payload_length (payload_length),
    .status         (status)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  stream_byte_t stream_q[$];
  box_report_t  box_reports_due[$];
  bit           next_hold = 1'b0;
  int           bytes_made = 0;
  int           boxes_planned = 0;
  int           bytes_in = 0;
  int           reports_seen = 0;
  int           errors = 0;
  int           input_stall_cycles = 0;
  int           cycles = 0;
  int           hold_at = 32'h7fff_ffff;
  bit           in_took = 1'b0;

  logic [3:0]  hdr_count = '0;
  logic [31:0] size_acc = '0;
  logic [31:0] type_acc = '0;
  logic [63:0] ext_acc = '0;
  logic [63:0] skip_left = '0;
  bit          stream_dead = 1'b0;

  function automatic bit known_box(input logic [31:0] t);
    bit hit = 1'b0;
    foreach (BOX_TYPES[i]) begin
      if (BOX_TYPES[i] == t) begin
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

  function automatic logic [31:0] stray_type();
    logic [31:0] t;
    do begin
      t = $urandom;
    end while (known_box(t));
    return t;
  endfunction

  task automatic walk_byte(input logic [7:0] b);
    box_report_t r;
    logic [63:0] len;
    status_t     st;
    if (stream_dead) begin
      return;
    end
    if (skip_left != 0) begin
      skip_left = skip_left - 64'd1;
      return;
    end
    if (hdr_count < 4) begin
      size_acc = {size_acc[23:0], b};
    end else if (hdr_count < 8) begin
      type_acc = {type_acc[23:0], b};
    end else begin
      ext_acc = {ext_acc[55:0], b};
    end
    hdr_count = hdr_count + 4'd1;
    if (hdr_count == SHORT_HEADER_BYTES && size_acc == SIZE_EXTENDED) begin
      return;
    end
    if (hdr_count != SHORT_HEADER_BYTES && hdr_count != 4'd0) begin
      return;
    end
    st = STATUS_OK;
    len = '0;
    if (size_acc == SIZE_EXTENDED) begin
      if (ext_acc < EXT_SIZE_MIN) begin
        st = STATUS_MALFORMED;
      end else begin
        len = ext_acc - EXT_SIZE_MIN;
      end
    end else if (size_acc == 32'd0) begin
      st = STATUS_SIZE_ZERO;
    end else if (size_acc < SIZE_MIN) begin
      st = STATUS_MALFORMED;
    end else begin
      len = {32'd0, size_acc - SIZE_MIN};
    end
    r.box_type = type_acc;
    r.len = len;
    r.st = st;
    hdr_count = '0;
    size_acc = '0;
    type_acc = '0;
    ext_acc = '0;
    if (st != STATUS_OK) begin
      stream_dead = 1'b1;
      box_reports_due.push_back(r);
    end else if (known_box(r.box_type)) begin
      skip_left = len;
      box_reports_due.push_back(r);
    end
  endtask

  task automatic put_byte(input logic [7:0] b);
    stream_q.push_back('{value: b, hold: next_hold});
    next_hold = 1'b0;
    bytes_made++;
  endtask

  task automatic put_be(input logic [63:0] v, input int nbytes);
    for (int i = nbytes - 1; i >= 0; i--) begin
      put_byte(v[8*i +: 8]);
    end
  endtask

  // A negative fill gives random payload bytes.
  task automatic put_box(input logic [31:0] size, input logic [31:0] t,
                         input logic [63:0] ext, input int n, input int fill);
    put_be({32'd0, size}, 4);
    put_be({32'd0, t}, 4);
    if (size == SIZE_EXTENDED) begin
      put_be(ext, 8);
    end
    for (int i = 0; i < n; i++) begin
      put_byte(fill < 0 ? 8'($urandom) : 8'(fill));
    end
  endtask

  task automatic put_known_box(input logic [31:0] t);
    int n;
    n = ($urandom_range(9, 0) == 0) ? $urandom_range(100, 0) : $urandom_range(12, 0);
    if ($urandom_range(3, 0) == 0) begin
      put_box(SIZE_EXTENDED, t, 64'(n + 16), n, -1);
    end else begin
      put_box(32'(n + 8), t, '0, n, -1);
    end
    boxes_planned++;
  endtask

  task automatic put_unknown_box();
    logic [31:0] size;
    logic [63:0] ext;
    size = $urandom;
    ext = {$urandom, $urandom};
    case ($urandom_range(2, 0))
      0: begin
        size = $urandom_range(40, 8);
      end
      1: begin
        if (size < SIZE_MIN) begin
          size = size + SIZE_MIN;
        end
      end
      default: begin
        size = SIZE_EXTENDED;
        if (ext < EXT_SIZE_MIN) begin
          ext = ext | EXT_SIZE_MIN;
        end
      end
    endcase
    put_box(size, stray_type(), ext, 0, -1);
  endtask

  // Input side: bursts of random length separated by random gaps.
  int burst_left = 0;
  int gap_left = 0;
  stream_byte_t next_item;

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_took) begin
      in_valid <= 1'b1;
    end else if (gap_left > 0) begin
      gap_left = gap_left - 1;
      in_valid <= 1'b0;
    end else if (stream_q.size() != 0 &&
                 !(stream_q[0].hold && box_reports_due.size() != 0)) begin
      in_valid <= 1'b1;
      next_item = stream_q.pop_front();
      data_byte <= next_item.value;
      if (burst_left <= 1) begin
        burst_left = ($urandom_range(5, 0) == 0) ? $urandom_range(300, 100)
                                                 : $urandom_range(30, 1);
        gap_left = $urandom_range(8, 0);
      end else begin
        burst_left = burst_left - 1;
      end
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Output side: randomly chosen stall modes, plus one long hold.
  int  stall_mode = 0;
  int  mode_left = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;

  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (!hold_done && bytes_in >= hold_at) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (mode_left == 0) begin
        stall_mode = $urandom_range(3, 0);
        mode_left = $urandom_range(100, 20);
      end
      mode_left = mode_left - 1;
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        out_stall <= 1'b1;
      end else begin
        case (stall_mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(3, 0) == 0);
          2: out_stall <= ($urandom_range(3, 0) != 0);
          default: out_stall <= !out_stall;
        endcase
      end
    end
  end

  // Results are checked before the byte taken at the same edge is predicted.
  always @(posedge clk) begin
    box_report_t want;
    if (rst) begin
      in_took = 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        reports_seen++;
        if (box_reports_due.size() == 0) begin
          $display("%0t: unexpected box report: expected none, actual type %h len %h status %0d",
                   $time, box_type, payload_length, status);
          errors++;
        end else begin
          want = box_reports_due.pop_front();
          if (box_type !== want.box_type) begin
            $display("%0t: box_type mismatch: expected %h actual %h",
                     $time, want.box_type, box_type);
            errors++;
          end
          if (payload_length !== want.len) begin
            $display("%0t: payload_length mismatch: expected %h actual %h",
                     $time, want.len, payload_length);
            errors++;
          end
          if (status !== want.st) begin
            $display("%0t: status mismatch: expected %0d actual %0d",
                     $time, want.st, status);
            errors++;
          end
        end
      end
      if (in_valid && in_stall) begin
        input_stall_cycles++;
      end
      in_took = in_valid && !in_stall;
      if (in_took) begin
        walk_byte(data_byte);
        bytes_in++;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d requests still due",
               $time, cycles, box_reports_due.size());
      $display("media_box_header_walker_top_test NOT OK");
      $finish;
    end
  end

  initial begin
    int    offset;
    int    k;
    string ending;

    put_box(32'd8, "ftyp", '0, 0, -1);
    put_box(32'd12, "moov", '0, 4, 8'h00);
    put_box(32'd12, "free", '0, 4, 8'hFF);
    put_box(32'd8, "abcd", '0, 0, -1);
    put_box(32'hFFFF_FFFF, 32'hFFFF_FFFF, '0, 0, -1);
    put_box(SIZE_EXTENDED, "mdat", 64'd16, 0, -1);
    put_box(SIZE_EXTENDED, "trak", 64'd19, 3, -1);
    put_box(SIZE_EXTENDED, 32'h0000_0000, 64'hFFFF_FFFF_FFFF_FFFF, 0, -1);
    put_box(32'd308, "uuid", '0, 300, -1);
    put_box(32'd8, "wfex", '0, 0, -1);
    put_box(32'h8000_0000, "zzzz", '0, 0, -1);
    put_box(32'd9, "skip", '0, 1, 8'h00);
    boxes_planned += 8;

    // Back-to-back empty boxes fill the result stages during the long output hold.
    hold_at = bytes_made;
    for (int i = 0; i < 12; i++) begin
      put_box(SIZE_MIN, BOX_TYPES[$urandom_range(TYPE_COUNT - 1, 0)], '0, 0, -1);
      boxes_planned++;
    end

    next_hold = 1'b1;
    offset = $urandom_range(TYPE_COUNT - 1, 0);
    k = 0;
    while (bytes_made < 760 || boxes_planned < 30) begin
      if ($urandom_range(24, 0) == 0) begin
        next_hold = 1'b1;
      end
      if ($urandom_range(9, 0) < 7) begin
        put_known_box(BOX_TYPES[(offset + k) % TYPE_COUNT]);
        k++;
      end else begin
        put_unknown_box();
      end
    end

    case ($urandom_range(2, 0))
      0: begin
        ending = "size zero";
        put_box(32'd0, BOX_TYPES[$urandom_range(TYPE_COUNT - 1, 0)], '0, 0, -1);
      end
      1: begin
        ending = "short size";
        put_box($urandom_range(7, 2), stray_type(), '0, 0, -1);
      end
      default: begin
        ending = "short extended size";
        put_box(SIZE_EXTENDED, BOX_TYPES[$urandom_range(TYPE_COUNT - 1, 0)],
                64'($urandom_range(15, 0)), 0, -1);
      end
    endcase
    for (int i = 0; i < 20; i++) begin
      put_byte(8'($urandom));
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    wait (bytes_in == bytes_made);
    while (box_reports_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Walked %0d stream bytes and checked %0d box requests;",
             bytes_in, reports_seen);
    $display("the stream ended on a %s header, and the input was stalled for %0d cycles.",
             ending, input_stall_cycles);
    if (errors == 0) begin
      $display("media_box_header_walker_top_test OK");
    end else begin
      $display("media_box_header_walker_top_test NOT OK");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/mbhw_pkg.sv
hdl/mbhw_walker.sv
hdl/media_box_header_walker_top.sv
sim/media_box_header_walker_top_test.sv
